[hw/rtl/running_mean_var_minmax_assert.svh]
`ifndef RUNNING_MEAN_VAR_MINMAX_ASSERT_SVH
`define RUNNING_MEAN_VAR_MINMAX_ASSERT_SVH
// Assertion helpers shared by the block.
`define RMV_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define RMV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[hw/rtl/rmv_pkg.sv]
package rmv_pkg;
   localparam int unsigned VAL_W = 32;
   localparam int unsigned SQ_W = 64;
   localparam logic [2:0] CSR_BURN_IN = 3'd0;
   localparam logic [2:0] CSR_THIN_STEP = 3'd1;
   localparam logic [2:0] CSR_VALUE_OFFSET = 3'd2;
   localparam logic [63:0] SUMSQ_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
endpackage

[hw/rtl/running_mean_var_minmax.sv]
// A kept item passes a bit-serial remainder loop in the front (the thinning test) and then
// the back, which performs two bit-serial 64-bit divisions. The back takes a new item only
// when idle, so it limits the rate of kept items; an item that fails the thinning test is
// dropped after the remainder loop, and one before burn-in or out of range at capture.
// Reset clears control state and configuration; statistic memories are not cleared.
module running_mean_var_minmax #(
   parameter int unsigned NUM_PARAMS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_iteration,
   input  logic [31:0]        req_sample_number,
   input  logic [5:0]         req_param_index,
   input  logic signed [31:0] req_sample_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_out_index,
   output logic signed [31:0] rsp_shifted_value,
   output logic signed [31:0] rsp_running_mean,
   output logic signed [63:0] rsp_running_variance,
   output logic signed [31:0] rsp_running_min,
   output logic signed [31:0] rsp_running_max,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data
);
   localparam int unsigned IDX_W = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
   logic [31:0] burn_in_ff;
   logic [15:0] thin_step_ff;
   logic signed [31:0] value_offset_ff;
   logic q_valid, q_ready;
   logic [IDX_W-1:0] q_index;
   logic [31:0] q_n;
   logic signed [31:0] q_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         burn_in_ff <= '0;
         thin_step_ff <= 16'd1;
         value_offset_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            rmv_pkg::CSR_BURN_IN: burn_in_ff <= csr_write_data;
            rmv_pkg::CSR_THIN_STEP: thin_step_ff <= csr_write_data[15:0];
            rmv_pkg::CSR_VALUE_OFFSET: value_offset_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   rmv_front #(.NUM_PARAMS(NUM_PARAMS), .IDX_W(IDX_W)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_iteration, .req_sample_number,
      .req_param_index, .req_sample_value, .burn_in(burn_in_ff), .thin_step(thin_step_ff),
      .value_offset(value_offset_ff), .q_valid, .q_ready, .q_index, .q_n, .q_x);

   rmv_back #(.NUM_PARAMS(NUM_PARAMS), .IDX_W(IDX_W)) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_index, .q_n, .q_x, .rsp_valid, .rsp_ready,
      .rsp_out_index, .rsp_shifted_value, .rsp_running_mean, .rsp_running_variance,
      .rsp_running_min, .rsp_running_max);
endmodule

[hw/rtl/rmv_ram.sv]
module rmv_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

[hw/rtl/rmv_front.sv]
module rmv_front #(
   parameter int unsigned NUM_PARAMS = 64,
   parameter int unsigned IDX_W = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [31:0]       req_iteration,
   input  logic [31:0]       req_sample_number,
   input  logic [5:0]        req_param_index,
   input  logic signed [31:0] req_sample_value,
   input  logic [31:0]       burn_in,
   input  logic [15:0]       thin_step,
   input  logic signed [31:0] value_offset,
   output logic              q_valid,
   input  logic              q_ready,
   output logic [IDX_W-1:0]  q_index,
   output logic [31:0]       q_n,
   output logic signed [31:0] q_x
);
   // Stage 1 captures the item; a remainder iteration then runs bit by bit.
   typedef enum logic [1:0] {S_IDLE, S_MOD, S_CHECK} state_type;
   state_type state_ff;
   logic [31:0] dvd_ff, rem_ff, n_ff;
   logic [15:0] step_ff;
   logic [5:0] cnt_ff;
   logic [5:0] idx_ff;
   logic signed [31:0] x_ff;
   logic [31:0] qd_n_ff;
   logic [IDX_W-1:0] qd_idx_ff;
   logic signed [31:0] qd_x_ff;
   logic qv_ff;
   logic signed [32:0] sum;
   logic signed [31:0] sat;
   logic [32:0] rsh;
   logic [31:0] rnext;

   assign sum = 33'(req_sample_value) + 33'(value_offset);
   always_comb begin
      if (sum[32] != sum[31]) begin
         sat = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sat = sum[31:0];
      end
   end
   assign rsh = {rem_ff, dvd_ff[31]};
   assign rnext = (rsh >= {17'd0, step_ff}) ? 32'(rsh - {17'd0, step_ff}) : rsh[31:0];

   assign req_ready = (state_ff == S_IDLE);
   assign q_valid = qv_ff;
   assign q_index = qd_idx_ff;
   assign q_n = qd_n_ff;
   assign q_x = qd_x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         qv_ff <= 1'b0;
      end else begin
         if (qv_ff && q_ready) begin
            qv_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  n_ff <= (req_sample_number == 32'd0) ? 32'd1 : req_sample_number;
                  idx_ff <= req_param_index;
                  x_ff <= sat;
                  step_ff <= (thin_step == 16'd0) ? 16'd1 : thin_step;
                  dvd_ff <= req_iteration - burn_in - 32'd1;
                  rem_ff <= '0;
                  cnt_ff <= '0;
                  if (req_iteration > burn_in && 32'(req_param_index) < NUM_PARAMS) begin
                     state_ff <= S_MOD;
                  end
               end
            end
            S_MOD: begin
               rem_ff <= rnext;
               dvd_ff <= {dvd_ff[30:0], 1'b0};
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd31) begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (rem_ff != 32'd0) begin
                  state_ff <= S_IDLE;
               end else if (!qv_ff || q_ready) begin
                  qv_ff <= 1'b1;
                  qd_n_ff <= n_ff;
                  qd_idx_ff <= IDX_W'(idx_ff);
                  qd_x_ff <= x_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[hw/rtl/rmv_back.sv]
`include "running_mean_var_minmax_assert.svh"
module rmv_back #(
   parameter int unsigned NUM_PARAMS = 64,
   parameter int unsigned IDX_W = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_ready,
   input  logic [IDX_W-1:0]   q_index,
   input  logic [31:0]        q_n,
   input  logic signed [31:0] q_x,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_out_index,
   output logic signed [31:0] rsp_shifted_value,
   output logic signed [31:0] rsp_running_mean,
   output logic signed [63:0] rsp_running_variance,
   output logic signed [31:0] rsp_running_min,
   output logic signed [31:0] rsp_running_max
);
   // Sequencer: read, multiply, 64-bit divide of mean numerator, then
   // divide sumsq by n, square of mean, write back and respond.
   typedef enum logic [3:0] {
      B_IDLE, B_READ, B_MUL1, B_MUL2, B_DIV1, B_DIV2, B_MSQ, B_OUT
   } state_type;
   state_type state_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [31:0] n_ff;
   logic signed [31:0] x_ff;
   logic signed [63:0] sq_ff, num_ff;
   logic [63:0] sumsq_ff;
   logic signed [31:0] mean_ff, min_ff, max_ff;
   logic [63:0] dq_ff;
   logic [32:0] dr_ff;
   logic [7:0] dc_ff;
   logic neg_ff;
   logic signed [63:0] msq_ff;
   logic wr_ff;
   logic rv_ff;
   logic [31:0] rd_mean;
   logic [63:0] rd_sumsq;
   logic [31:0] rd_min, rd_max;
   logic [33:0] dsh;
   logic [33:0] dsub;
   logic signed [63:0] qs;
   logic [63:0] sqsum;
   logic [64:0] sqadd;

   rmv_ram #(.WIDTH(32), .DEPTH(2**IDX_W)) u_mean (.clock, .wr_en(wr_ff), .wr_addr(idx_ff),
      .wr_data(mean_ff), .rd_addr(idx_ff), .rd_data(rd_mean));
   rmv_ram #(.WIDTH(64), .DEPTH(2**IDX_W)) u_sumsq (.clock, .wr_en(wr_ff), .wr_addr(idx_ff),
      .wr_data(sumsq_ff), .rd_addr(idx_ff), .rd_data(rd_sumsq));
   rmv_ram #(.WIDTH(32), .DEPTH(2**IDX_W)) u_min (.clock, .wr_en(wr_ff), .wr_addr(idx_ff),
      .wr_data(min_ff), .rd_addr(idx_ff), .rd_data(rd_min));
   rmv_ram #(.WIDTH(32), .DEPTH(2**IDX_W)) u_max (.clock, .wr_en(wr_ff), .wr_addr(idx_ff),
      .wr_data(max_ff), .rd_addr(idx_ff), .rd_data(rd_max));

   assign dsh = {dr_ff, dq_ff[63]};
   assign dsub = dsh - {2'd0, n_ff};
   assign qs = neg_ff ? -$signed(dq_ff) : $signed(dq_ff);
   assign sqadd = {1'b0, sumsq_ff} + {1'b0, sq_ff};
   assign sqsum = (sqadd > {1'b0, rmv_pkg::SUMSQ_MAX}) ? rmv_pkg::SUMSQ_MAX : sqadd[63:0];

   assign q_ready = (state_ff == B_IDLE);
   assign rsp_valid = rv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         rv_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         wr_ff <= 1'b0;
         if (rv_ff && rsp_ready) begin
            rv_ff <= 1'b0;
         end
         case (state_ff)
            B_IDLE: begin
               if (q_valid) begin
                  idx_ff <= q_index;
                  n_ff <= q_n;
                  x_ff <= q_x;
                  state_ff <= B_READ;
               end
            end
            B_READ: begin
               sq_ff <= x_ff * x_ff;
               state_ff <= B_MUL1;
            end
            B_MUL1: begin
               if (n_ff == 32'd1) begin
                  mean_ff <= x_ff;
                  sumsq_ff <= sq_ff;
                  min_ff <= x_ff;
                  max_ff <= x_ff;
               end else begin
                  num_ff <= $signed({1'b0, n_ff - 32'd1}) * $signed(rd_mean);
                  sumsq_ff <= rd_sumsq;
                  min_ff <= (x_ff < $signed(rd_min)) ? x_ff : $signed(rd_min);
                  max_ff <= (x_ff > $signed(rd_max)) ? x_ff : $signed(rd_max);
               end
               state_ff <= B_MUL2;
            end
            B_MUL2: begin
               if (n_ff == 32'd1) begin
                  num_ff <= 64'(x_ff);
               end else begin
                  num_ff <= num_ff + 64'(x_ff);
                  sumsq_ff <= sqsum;
               end
               state_ff <= B_DIV1;
               dc_ff <= '0;
               dr_ff <= '0;
            end
            B_DIV1: begin
               if (dc_ff == 8'd0) begin
                  neg_ff <= num_ff[63];
                  dq_ff <= num_ff[63] ? 64'(-num_ff) : num_ff;
                  dc_ff <= 8'd1;
               end else begin
                  dq_ff <= {dq_ff[62:0], ~dsub[33]};
                  dr_ff <= dsub[33] ? dsh[32:0] : dsub[32:0];
                  dc_ff <= dc_ff + 8'd1;
                  if (dc_ff == 8'd64) begin
                     state_ff <= B_DIV2;
                  end
               end
            end
            B_DIV2: begin
               if (dc_ff == 8'd65) begin
                  mean_ff <= 32'(qs);
                  dq_ff <= sumsq_ff;
                  dr_ff <= '0;
                  dc_ff <= 8'd66;
               end else begin
                  dq_ff <= {dq_ff[62:0], ~dsub[33]};
                  dr_ff <= dsub[33] ? dsh[32:0] : dsub[32:0];
                  dc_ff <= dc_ff + 8'd1;
                  if (dc_ff == 8'd129) begin
                     state_ff <= B_MSQ;
                  end
               end
            end
            B_MSQ: begin
               msq_ff <= mean_ff * mean_ff;
               wr_ff <= 1'b1;
               state_ff <= B_OUT;
            end
            B_OUT: begin
               if (!rv_ff || rsp_ready) begin
                  rv_ff <= 1'b1;
                  rsp_out_index <= 6'(idx_ff);
                  rsp_shifted_value <= x_ff;
                  rsp_running_mean <= mean_ff;
                  rsp_running_variance <= $signed(dq_ff) - msq_ff;
                  rsp_running_min <= min_ff;
                  rsp_running_max <= max_ff;
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   `RMV_ASSERT_IMPL(a_wr_then_out, clock, reset, wr_ff, state_ff == B_OUT)
   `RMV_ASSERT_IMPL(a_wr_in_msq, clock, reset, wr_ff, $past(state_ff) == B_MSQ)
   `RMV_ASSERT_NEXT(a_rsp_hold, clock, reset, rv_ff && !rsp_ready, rv_ff)
endmodule
